/* rtl/core/mawf_pkg.sv */
// ----------------------------------------------------------------------------
// mawf_pkg
// Shared constants and types of the minimum average window finder.
// ----------------------------------------------------------------------------
package mawf_pkg;

    localparam int MAX_ELEMENTS_DEF  = 1024;
    localparam int FRACTION_BITS_DEF = 20;

    localparam int COST_W   = 7;
    localparam int COST_MAX = 127;
    localparam int CFG_W    = 11;
    localparam int AVG_W    = 27;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_READ,
        ST_DIFF,
        ST_MUL,
        ST_CMP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } t_state;

endpackage

/* rtl/core/mawf_prefix_mem.sv */
// ----------------------------------------------------------------------------
// mawf_prefix_mem
// Prefix sum store: one write port, two registered read ports.
// Address zero always reads as zero and is never written.
// ----------------------------------------------------------------------------
module mawf_prefix_mem #(
    parameter int MAX_ELEMENTS = mawf_pkg::MAX_ELEMENTS_DEF,
    parameter int ADDR_W       = $clog2(MAX_ELEMENTS + 1),
    parameter int DATA_W       = $clog2(MAX_ELEMENTS * mawf_pkg::COST_MAX + 1)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);
    logic [DATA_W-1:0] r_mem [MAX_ELEMENTS:0];
    logic [DATA_W-1:0] r_data_a;
    logic [DATA_W-1:0] r_data_b;
    logic              r_zero_a;
    logic              r_zero_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data_a <= r_mem[i_raddr_a];
        r_data_b <= r_mem[i_raddr_b];
        r_zero_a <= (i_raddr_a == '0);
        r_zero_b <= (i_raddr_b == '0);
    end

    assign o_rdata_a = r_zero_a ? '0 : r_data_a;
    assign o_rdata_b = r_zero_b ? '0 : r_data_b;

endmodule

/* rtl/core/mawf_divider.sv */
// ----------------------------------------------------------------------------
// mawf_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mawf_divider #(
    parameter int DVD_W = 37,
    parameter int DVS_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_trial;
    logic             w_ge;
    logic [DVS_W:0]   w_diff;

    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                // shift in one dividend bit, subtract where it fits
                r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], w_ge};
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/core/min_average_window_finder.sv */
// ----------------------------------------------------------------------------
// min_average_window_finder
// Loads a cost sequence into a prefix sum store and, after the item marked
// last, reports the smallest average over all windows of at least
// min_length elements as a truncated fixed-point value.
// ----------------------------------------------------------------------------
// Input transactions are taken while a sequence is loading.
// After the last item the block searches every window with one shared
// read-subtract-multiply-compare loop around the two read ports of the
// prefix store, stepping through ST_READ, ST_DIFF, ST_MUL and ST_CMP for
// each window, followed by a bit-serial divide of the best window sum by
// its length. For n elements and minimum length m, if m exceeds n no window
// is searched and the result goes straight to the output register. Input
// is blocked during the search; a waiting result does not block loading of
// the next sequence.
// ----------------------------------------------------------------------------
module min_average_window_finder #(
    parameter int MAX_ELEMENTS  = mawf_pkg::MAX_ELEMENTS_DEF,
    parameter int FRACTION_BITS = mawf_pkg::FRACTION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mawf_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [mawf_pkg::COST_W-1:0] i_cost,
    input  logic                        i_last,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [mawf_pkg::AVG_W-1:0]  o_min_average,
    output logic                        o_found
);
    import mawf_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int SUM_W  = $clog2(MAX_ELEMENTS * COST_MAX + 1);
    localparam int PROD_W = SUM_W + CNT_W;
    localparam int Q_W    = SUM_W + FRACTION_BITS;
    localparam int CMP_W  = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    t_state             r_state;
    t_state             n_state;
    logic [CFG_W-1:0]   r_min_length;
    logic [CNT_W-1:0]   r_count;
    logic [SUM_W-1:0]   r_acc;
    logic [CNT_W-1:0]   r_len;
    logic [CNT_W-1:0]   r_end;
    logic [SUM_W-1:0]   r_cand;
    logic [PROD_W-1:0]  r_prod_cand;
    logic [PROD_W-1:0]  r_prod_best;
    logic [SUM_W-1:0]   r_best_sum;
    logic [CNT_W-1:0]   r_best_len;
    logic               r_found;
    logic               r_out_valid;
    logic [AVG_W-1:0]   r_out_avg;
    logic               r_out_found;

    logic [CFG_W-1:0]   w_minlen;
    logic               w_no_window;
    logic               w_last_end;
    logic               w_last_len;
    logic               w_better;
    logic               w_load;
    logic               w_store;
    logic               w_out_free;
    logic [SUM_W-1:0]   w_new_sum;
    logic [SUM_W-1:0]   w_rd_a;
    logic [SUM_W-1:0]   w_rd_b;
    logic               w_div_start;
    logic               w_div_done;
    logic [Q_W-1:0]     w_div_quot;
    logic [Q_W+AVG_W-1:0] w_quot_ext;

    assign w_minlen    = (r_min_length == '0) ? CFG_W'(1) : r_min_length;
    assign w_no_window = CMP_W'(w_minlen) > CMP_W'(r_count);
    assign w_last_end  = (r_end == r_count);
    assign w_last_len  = (r_len == r_count);
    assign w_better    = !r_found || (r_prod_cand < r_prod_best);
    assign w_load      = i_in_valid && o_in_ready;
    assign w_store     = w_load && (r_count != CNT_W'(MAX_ELEMENTS));
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_new_sum   = r_acc + SUM_W'(i_cost);
    assign w_quot_ext  = {{AVG_W{1'b0}}, w_div_quot};

    mawf_prefix_mem #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .ADDR_W       (CNT_W),
        .DATA_W       (SUM_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (w_store),
        .i_waddr   (r_count + 1'b1),
        .i_wdata   (w_new_sum),
        .i_raddr_a (r_end),
        .i_raddr_b (r_end - r_len),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    mawf_divider #(
        .DVD_W (Q_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({r_best_sum, {FRACTION_BITS{1'b0}}}),
        .i_divisor  (r_best_len),
        .o_done     (w_div_done),
        .o_quotient (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (w_load && i_last) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_state = w_no_window ? ST_OUT : ST_READ;
            end
            ST_READ: n_state = ST_DIFF;
            ST_DIFF: n_state = ST_MUL;
            ST_MUL:  n_state = ST_CMP;
            ST_CMP: begin
                n_state = (w_last_end && w_last_len) ? ST_DIV_GO : ST_READ;
            end
            ST_DIV_GO: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= CFG_W'(1);
            r_count      <= '0;
            r_acc        <= '0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_length <= i_cfg_wdata;
            end
            if (r_out_valid && i_out_ready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_LOAD: begin
                    // drop elements beyond the store, keep the last mark
                    if (w_store) begin
                        r_acc   <= w_new_sum;
                        r_count <= r_count + 1'b1;
                    end
                end
                ST_START: begin
                    r_found <= 1'b0;
                    r_len   <= CNT_W'(w_minlen);
                    r_end   <= CNT_W'(w_minlen);
                end
                ST_DIFF: begin
                    r_cand <= w_rd_a - w_rd_b;
                end
                ST_MUL: begin
                    // cross multiply to compare the two fractions exactly
                    r_prod_cand <= PROD_W'(r_cand) * PROD_W'(r_best_len);
                    r_prod_best <= PROD_W'(r_best_sum) * PROD_W'(r_len);
                end
                ST_CMP: begin
                    if (w_better) begin
                        r_best_sum <= r_cand;
                        r_best_len <= r_len;
                        r_found    <= 1'b1;
                    end
                    if (!w_last_end) begin
                        r_end <= r_end + 1'b1;
                    end else if (!w_last_len) begin
                        r_len <= r_len + 1'b1;
                        r_end <= r_len + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_found;
                        r_out_avg   <= r_found ? w_quot_ext[AVG_W-1:0] : '0;
                        r_count     <= '0;
                        r_acc       <= '0;
                        r_found     <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_min_average = r_out_avg;
    assign o_found       = r_out_found;

endmodule

/* rtl/core/mawf_checker.sv */
// ----------------------------------------------------------------------------
// mawf_checker
// Port-level checks of the minimum average window finder, bound to the top.
// ----------------------------------------------------------------------------
module mawf_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       i_last,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [mawf_pkg::AVG_W-1:0] o_min_average,
    input logic                       o_found
);
    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_min_average) && $stable(o_found))
        else $error("result changed while stalled");

    a_no_window_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_min_average == '0)
        else $error("nonzero average without a window");

    // the search blocks input right after the last transaction
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last |=> !o_in_ready)
        else $error("input taken during the search");

endmodule

bind min_average_window_finder mawf_checker u_mawf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_last        (i_last),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_min_average (o_min_average),
    .o_found       (o_found)
);
